FILE: rtl/core/dpcc_pkg.sv
`timescale 1ns / 1ps

package dpcc_pkg;

    // Channel count and derived table geometry
    localparam int NUM_CHANNELS = 16;
    localparam int SEG_N        = 4;
    localparam int CH_IDX_W     = $clog2(NUM_CHANNELS);
    localparam int TBL_DEPTH    = NUM_CHANNELS * SEG_N;
    localparam int TBL_AW       = CH_IDX_W + $clog2(SEG_N);

    // Datapath widths
    localparam int V_W      = 16;
    localparam int RATIO_W  = 24;
    localparam int OFFS_W   = 24;
    localparam int STEP_W   = 16;
    localparam int PROD_W   = V_W + RATIO_W;
    localparam int ADDEND_W = 38;
    localparam int SUM_W    = PROD_W + 1;
    localparam int FRAC_W   = 20;
    localparam int OFFS_SH  = 12;
    localparam int Q_W      = SUM_W - FRAC_W;
    localparam int CODE_W   = 16;

    // Voltage limits and segment knees, millivolts
    localparam logic signed [V_W-1:0] V_MAX   = 16'sd25000;
    localparam logic signed [V_W-1:0] V_MIN   = -16'sd25000;
    localparam logic signed [V_W-1:0] V_KNEE  = 16'sd10000;
    localparam logic signed [V_W-1:0] V_NKNEE = -16'sd10000;

    localparam logic signed [Q_W-1:0] CODE_MAX = 21'sd32767;
    localparam logic signed [Q_W-1:0] CODE_MIN = -21'sd32768;

    localparam logic [4:0] ADDR_BASE = 5'd20;

    // Item modes
    localparam logic MODE_CONVERT = 1'b0;
    localparam logic MODE_CAL     = 1'b1;

    // Calibration slots
    localparam logic [3:0] SLOT_RATIO_LO  = 4'd0;
    localparam logic [3:0] SLOT_RATIO_HI  = 4'd3;
    localparam logic [3:0] SLOT_OFFS_LO   = 4'd4;
    localparam logic [3:0] SLOT_OFFS_HI   = 4'd7;
    localparam logic [3:0] SLOT_ZERO_STEP = 4'd8;
    localparam logic [3:0] SLOT_NEG_STEP  = 4'd9;

    typedef enum logic [1:0] {
        CONV_A    = 2'd0,
        CONV_B    = 2'd1,
        CONV_C    = 2'd2,
        CONV_NONE = 2'd3
    } t_conv;

    typedef enum logic [1:0] {
        SEG_POS_LOW  = 2'd0,
        SEG_POS_HIGH = 2'd1,
        SEG_NEG_LOW  = 2'd2,
        SEG_NEG_HIGH = 2'd3
    } t_seg;

    // Calibration write request
    typedef struct packed {
        logic                 en_ratio;
        logic                 en_offs;
        logic                 en_zs;
        logic                 en_nzs;
        logic [TBL_AW-1:0]    addr;
        logic [CH_IDX_W-1:0]  ch;
        logic [RATIO_W-1:0]   value;
    } t_cal_wr;

    // Calibration lookup request
    typedef struct packed {
        logic                 load;
        logic                 ch_ok;
        logic                 neg;
        logic [CH_IDX_W-1:0]  ch;
        t_seg                 seg;
    } t_cal_rd;

    typedef struct packed {
        logic signed [RATIO_W-1:0] ratio;
        logic signed [OFFS_W-1:0]  offset;
        logic [STEP_W-1:0]         step;
    } t_cal_data;

    // Fields that ride along the pipeline untouched
    typedef struct packed {
        logic signed [V_W-1:0] v;
        t_conv                 conv;
        logic [4:0]            addr;
    } t_side;

    typedef struct packed {
        t_side     side;
        logic      neg;
        t_cal_data cal;
    } t_s1;

endpackage

FILE: rtl/core/dpcc_if.sv
`timescale 1ns / 1ps

interface dpcc_cmd_if;
    logic               valid;
    logic               ready;
    logic               mode;
    logic [3:0]         channel;
    logic signed [15:0] voltage_mv;
    logic [3:0]         cal_slot;
    logic signed [23:0] cal_value;

    modport source (
        output valid, mode, channel, voltage_mv, cal_slot, cal_value,
        input  ready
    );
    modport sink (
        input  valid, mode, channel, voltage_mv, cal_slot, cal_value,
        output ready
    );
endinterface

interface dpcc_res_if;
    logic               valid;
    logic               ready;
    logic [1:0]         converter_select;
    logic [4:0]         register_address;
    logic [7:0]         code_high;
    logic [7:0]         code_low;
    logic signed [15:0] clamped_mv;
    logic               code_saturated;

    modport source (
        output valid, converter_select, register_address, code_high, code_low,
               clamped_mv, code_saturated,
        input  ready
    );
    modport sink (
        input  valid, converter_select, register_address, code_high, code_low,
               clamped_mv, code_saturated,
        output ready
    );
endinterface

FILE: rtl/core/dac_piecewise_calibrated_code_core.sv
`timescale 1ns / 1ps

// Piecewise-linear calibrated DAC code generator.
//
// i_cmd carries one item per transfer. A convert item (mode 0) takes a
// channel and a voltage in mV, clamps it to +/-25000, picks one of four
// segments and forms ratio * v + offset +/- zero step in Q.20, truncated
// toward zero and saturated to a signed 16-bit code. Its result leaves on
// o_res as converter select, register address and the two code bytes.
// A calibration item (mode 1) writes one word of the per-channel tables and
// produces no transfer on o_res; it takes effect for the very next item.
//
// A convert result passes the lookup, multiply, sum and truncate/saturate
// registers in that order on its way to o_res. Throughput is one item
// per cycle while o_res is ready; the 24x16 multiplier stage sets the
// clock limit. When o_res stalls, the four-stage pipeline keeps filling
// its bubbles and i_cmd.ready drops only once every stage holds an item;
// nothing is lost or repeated.
// Reset (synchronous, active low) clears the pipeline valids, the zero-step
// registers and the table valid bits, so every table entry reads as zero
// until written. No clearing pass is needed.

module dac_piecewise_calibrated_code_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    dpcc_cmd_if.sink   i_cmd,
    dpcc_res_if.source o_res
);
    import dpcc_pkg::*;

    logic      accept;
    logic      ch_ok;
    logic      s2_ready;
    logic      s1_ready;

    logic signed [V_W-1:0] v_clamp;
    logic                  v_neg;
    t_seg                  seg;
    t_conv                 conv;
    logic [4:0]            reg_addr;

    t_cal_wr   cal_wr;
    t_cal_rd   cal_rd;
    t_cal_data cal_data;
    t_s1       s1;

    // Stage 1 registers (table read data is registered in the store)
    logic                  r1_vld;
    logic signed [V_W-1:0] r1_v;
    logic                  r1_neg;
    t_conv                 r1_conv;
    logic [4:0]            r1_addr;

    assign s1_ready    = !r1_vld || s2_ready;
    assign i_cmd.ready = s1_ready;
    assign accept      = i_cmd.valid && s1_ready;
    assign ch_ok       = int'(i_cmd.channel) < NUM_CHANNELS;

    // Clamp and segment select
    always_comb begin
        if (i_cmd.voltage_mv > V_MAX) begin
            v_clamp = V_MAX;
        end else if (i_cmd.voltage_mv < V_MIN) begin
            v_clamp = V_MIN;
        end else begin
            v_clamp = i_cmd.voltage_mv;
        end
        v_neg = v_clamp[V_W-1];
        if (!v_neg) begin
            seg = (v_clamp <= V_KNEE) ? SEG_POS_LOW : SEG_POS_HIGH;
        end else begin
            seg = (v_clamp >= V_NKNEE) ? SEG_NEG_LOW : SEG_NEG_HIGH;
        end
    end

    // Channel to converter / sub-channel map
    always_comb begin
        if (i_cmd.channel inside {[4'd0:4'd1]}) begin
            conv     = CONV_A;
            reg_addr = ADDR_BASE + {1'b0, i_cmd.channel};
        end else if (i_cmd.channel inside {[4'd2:4'd9]}) begin
            conv     = CONV_B;
            reg_addr = ADDR_BASE + {1'b0, i_cmd.channel - 4'd2};
        end else if (i_cmd.channel inside {[4'd10:4'd13]}) begin
            conv     = CONV_C;
            reg_addr = ADDR_BASE + {1'b0, i_cmd.channel - 4'd10};
        end else begin
            conv     = CONV_NONE;
            reg_addr = ADDR_BASE;
        end
    end

    // Calibration writes happen at the accepting edge
    always_comb begin
        cal_wr          = '0;
        cal_wr.addr     = {CH_IDX_W'(i_cmd.channel), i_cmd.cal_slot[1:0]};
        cal_wr.ch       = CH_IDX_W'(i_cmd.channel);
        cal_wr.value    = i_cmd.cal_value;
        if (accept && i_cmd.mode == MODE_CAL && ch_ok) begin
            cal_wr.en_ratio = i_cmd.cal_slot inside {[SLOT_RATIO_LO:SLOT_RATIO_HI]};
            cal_wr.en_offs  = i_cmd.cal_slot inside {[SLOT_OFFS_LO:SLOT_OFFS_HI]};
            cal_wr.en_zs    = i_cmd.cal_slot == SLOT_ZERO_STEP;
            cal_wr.en_nzs   = i_cmd.cal_slot == SLOT_NEG_STEP;
        end
    end

    assign cal_rd.load  = accept && i_cmd.mode == MODE_CONVERT;
    assign cal_rd.ch_ok = ch_ok;
    assign cal_rd.neg   = v_neg;
    assign cal_rd.ch    = CH_IDX_W'(i_cmd.channel);
    assign cal_rd.seg   = seg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
        end else if (s1_ready) begin
            r1_vld <= cal_rd.load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (cal_rd.load) begin
            r1_v    <= v_clamp;
            r1_neg  <= v_neg;
            r1_conv <= conv;
            r1_addr <= reg_addr;
        end
    end

    dpcc_cal_store u_cal_store (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (cal_wr),
        .i_rd    (cal_rd),
        .o_data  (cal_data)
    );

    assign s1.side.v    = r1_v;
    assign s1.side.conv = r1_conv;
    assign s1.side.addr = r1_addr;
    assign s1.neg       = r1_neg;
    assign s1.cal       = cal_data;

    dpcc_arith u_arith (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s1_vld   (r1_vld),
        .i_s1       (s1),
        .o_s1_ready (s2_ready),
        .o_res      (o_res)
    );

endmodule

FILE: rtl/core/dpcc_cal_store.sv
`timescale 1ns / 1ps

module dpcc_cal_store (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  dpcc_pkg::t_cal_wr   i_wr,
    input  dpcc_pkg::t_cal_rd   i_rd,
    output dpcc_pkg::t_cal_data o_data
);
    import dpcc_pkg::*;

    logic [RATIO_W-1:0]   r_ratio_mem [TBL_DEPTH];
    logic [OFFS_W-1:0]    r_offs_mem  [TBL_DEPTH];
    logic [TBL_DEPTH-1:0] r_ratio_vld;
    logic [TBL_DEPTH-1:0] r_offs_vld;
    logic [STEP_W-1:0]    r_zs  [NUM_CHANNELS];
    logic [STEP_W-1:0]    r_nzs [NUM_CHANNELS];

    logic [RATIO_W-1:0] r_ratio_q;
    logic [OFFS_W-1:0]  r_offs_q;
    logic               r_ratio_ok;
    logic               r_offs_ok;
    logic [STEP_W-1:0]  r_step;

    logic [TBL_AW-1:0]  rd_addr;

    assign rd_addr = {i_rd.ch, i_rd.seg};

    // Table memories, no reset; valid bits mask unwritten entries
    always_ff @(posedge i_clk) begin
        if (i_wr.en_ratio) begin
            r_ratio_mem[i_wr.addr] <= i_wr.value;
        end
        if (i_wr.en_offs) begin
            r_offs_mem[i_wr.addr] <= i_wr.value;
        end
        if (i_rd.load) begin
            r_ratio_q <= r_ratio_mem[rd_addr];
            r_offs_q  <= r_offs_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ratio_vld <= '0;
            r_offs_vld  <= '0;
            r_zs        <= '{default: '0};
            r_nzs       <= '{default: '0};
        end else begin
            if (i_wr.en_ratio) begin
                r_ratio_vld[i_wr.addr] <= 1'b1;
            end
            if (i_wr.en_offs) begin
                r_offs_vld[i_wr.addr] <= 1'b1;
            end
            if (i_wr.en_zs) begin
                r_zs[i_wr.ch] <= i_wr.value[STEP_W-1:0];
            end
            if (i_wr.en_nzs) begin
                r_nzs[i_wr.ch] <= i_wr.value[STEP_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd.load) begin
            r_ratio_ok <= i_rd.ch_ok && r_ratio_vld[rd_addr];
            r_offs_ok  <= i_rd.ch_ok && r_offs_vld[rd_addr];
            if (!i_rd.ch_ok) begin
                r_step <= '0;
            end else if (i_rd.neg) begin
                r_step <= r_nzs[i_rd.ch];
            end else begin
                r_step <= r_zs[i_rd.ch];
            end
        end
    end

    assign o_data.ratio  = r_ratio_ok ? signed'(r_ratio_q) : '0;
    assign o_data.offset = r_offs_ok  ? signed'(r_offs_q)  : '0;
    assign o_data.step   = r_step;

endmodule

FILE: rtl/core/dpcc_arith.sv
`timescale 1ns / 1ps

module dpcc_arith (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_s1_vld,
    input  dpcc_pkg::t_s1 i_s1,
    output logic          o_s1_ready,
    dpcc_res_if.source    o_res
);
    import dpcc_pkg::*;

    logic en2, en3, en4;

    // Stage 2: product and scaled addend
    logic                       r2_vld;
    logic signed [PROD_W-1:0]   r2_prod;
    logic signed [ADDEND_W-1:0] r2_addend;
    t_side                      r2_side;

    // Stage 3: full Q.20 sum
    logic                       r3_vld;
    logic signed [SUM_W-1:0]    r3_sum;
    t_side                      r3_side;

    // Stage 4: output register
    logic                       r4_vld;
    logic [CODE_W-1:0]          r4_code;
    logic                       r4_sat;
    t_side                      r4_side;

    logic signed [ADDEND_W-1:0] offs_sc;
    logic signed [ADDEND_W-1:0] step_sc;
    logic signed [Q_W-1:0]      q_floor;
    logic signed [Q_W-1:0]      q_trunc;
    logic                       frac_nz;

    assign en4        = !r4_vld || o_res.ready;
    assign en3        = !r3_vld || en4;
    assign en2        = !r2_vld || en3;
    assign o_s1_ready = en2;

    assign offs_sc = signed'({{(ADDEND_W - OFFS_W - OFFS_SH){i_s1.cal.offset[OFFS_W-1]}},
                              i_s1.cal.offset, {OFFS_SH{1'b0}}});
    assign step_sc = signed'({{(ADDEND_W - STEP_W - FRAC_W){1'b0}},
                              i_s1.cal.step, {FRAC_W{1'b0}}});

    // Divide by 2^20 toward zero: floor, then bump negatives with a remainder
    assign q_floor = r3_sum[SUM_W-1:FRAC_W];
    assign frac_nz = |r3_sum[FRAC_W-1:0];
    assign q_trunc = q_floor + Q_W'(r3_sum[SUM_W-1] && frac_nz);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_vld <= 1'b0;
            r3_vld <= 1'b0;
            r4_vld <= 1'b0;
        end else begin
            if (en2) r2_vld <= i_s1_vld;
            if (en3) r3_vld <= r2_vld;
            if (en4) r4_vld <= r3_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en2) begin
            r2_prod   <= i_s1.side.v * i_s1.cal.ratio;
            r2_addend <= i_s1.neg ? (offs_sc - step_sc) : (offs_sc + step_sc);
            r2_side   <= i_s1.side;
        end
        if (en3) begin
            r3_sum  <= SUM_W'(r2_prod) + SUM_W'(r2_addend);
            r3_side <= r2_side;
        end
        if (en4) begin
            r4_side <= r3_side;
            if (q_trunc > CODE_MAX) begin
                r4_code <= CODE_W'(CODE_MAX);
                r4_sat  <= 1'b1;
            end else if (q_trunc < CODE_MIN) begin
                r4_code <= CODE_W'(CODE_MIN);
                r4_sat  <= 1'b1;
            end else begin
                r4_code <= q_trunc[CODE_W-1:0];
                r4_sat  <= 1'b0;
            end
        end
    end

    assign o_res.valid            = r4_vld;
    assign o_res.converter_select = r4_side.conv;
    assign o_res.register_address = r4_side.addr;
    assign o_res.code_high        = r4_code[CODE_W-1:8];
    assign o_res.code_low         = r4_code[7:0];
    assign o_res.clamped_mv       = r4_side.v;
    assign o_res.code_saturated   = r4_sat;

    a_sat_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r4_vld && r4_sat |-> (r4_code == 16'h7fff || r4_code == 16'h8000))
        else $error("saturated result without a rail code");

    a_clamp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r4_vld |-> (r4_side.v <= V_MAX && r4_side.v >= V_MIN))
        else $error("clamped voltage out of range");

    a_unmapped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r4_vld && r4_side.conv == CONV_NONE |-> r4_side.addr == ADDR_BASE)
        else $error("unmapped channel with nonbase address");

    a_s2_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r2_vld && !en3 |=> r2_vld && $stable(r2_prod) && $stable(r2_addend))
        else $error("stage 2 changed while stalled");

endmodule

FILE: test/dpcc_checker.sv
`timescale 1ns / 1ps

// Watches both channels, predicts each DAC command and compares in order.
module dpcc_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    dpcc_cmd_if  i_cmd,
    dpcc_res_if  i_res,
    output int   o_err_count,
    output int   o_pending
);
    import dpcc_pkg::*;

    typedef struct packed {
        t_conv                 conv;
        logic [4:0]            addr;
        logic [7:0]            code_hi;
        logic [7:0]            code_lo;
        logic signed [V_W-1:0] mv;
        logic                  sat;
    } t_dac_cmd;

    logic signed [RATIO_W-1:0] ratio_tbl     [TBL_DEPTH];
    logic signed [OFFS_W-1:0]  offset_tbl    [TBL_DEPTH];
    logic [STEP_W-1:0]         zero_step_tbl [NUM_CHANNELS];
    logic [STEP_W-1:0]         neg_step_tbl  [NUM_CHANNELS];

    t_dac_cmd dac_cmd_q[$];
    int       err_count = 0;
    int       pending   = 0;

    assign o_err_count = err_count;
    assign o_pending   = pending;

    // Clamp, segment lookup, Q.20 sum, truncate toward zero, saturate.
    function automatic t_dac_cmd calibrate_code(logic [3:0] ch, logic signed [V_W-1:0] vin);
        t_dac_cmd              r;
        logic signed [V_W-1:0] v;
        t_seg                  seg;
        longint                acc;
        longint                q;
        logic [CODE_W-1:0]     code;
        int                    idx;
        if (ch < 2) begin
            r.conv = CONV_A;
            r.addr = ADDR_BASE + 5'(ch);
        end else if (ch < 10) begin
            r.conv = CONV_B;
            r.addr = ADDR_BASE + 5'(ch - 2);
        end else if (ch < 14) begin
            r.conv = CONV_C;
            r.addr = ADDR_BASE + 5'(ch - 10);
        end else begin
            r.conv = CONV_NONE;
            r.addr = ADDR_BASE;
        end
        v = vin;
        if (v > V_MAX) v = V_MAX;
        if (v < V_MIN) v = V_MIN;
        if (v >= 0) seg = (v <= V_KNEE) ? SEG_POS_LOW : SEG_POS_HIGH;
        else        seg = (v >= V_NKNEE) ? SEG_NEG_LOW : SEG_NEG_HIGH;
        acc = 0;
        if (int'(ch) < NUM_CHANNELS) begin
            idx = int'(ch) * SEG_N + int'(seg);
            acc = longint'(v) * longint'(ratio_tbl[idx]) + longint'(offset_tbl[idx]) * 4096;
            if (v >= 0) acc = acc + longint'(zero_step_tbl[ch]) * 1048576;
            else        acc = acc - longint'(neg_step_tbl[ch]) * 1048576;
        end
        q     = acc / 1048576;
        r.sat = 1'b0;
        if (q > 32767) begin
            q     = 32767;
            r.sat = 1'b1;
        end
        if (q < -32768) begin
            q     = -32768;
            r.sat = 1'b1;
        end
        code      = q[CODE_W-1:0];
        r.code_hi = code[15:8];
        r.code_lo = code[7:0];
        r.mv      = v;
        return r;
    endfunction

    task automatic check_field(string name, int want, int got);
        if (want != got) begin
            err_count++;
            $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
    endtask

    always @(posedge i_clk) begin : monitor
        t_dac_cmd   want;
        logic [3:0] slot;
        int         ch;
        if (!i_rst_n) begin
            for (int i = 0; i < TBL_DEPTH; i++) begin
                ratio_tbl[i]  = '0;
                offset_tbl[i] = '0;
            end
            for (int i = 0; i < NUM_CHANNELS; i++) begin
                zero_step_tbl[i] = '0;
                neg_step_tbl[i]  = '0;
            end
            dac_cmd_q.delete();
        end else begin
            if (i_res.valid && i_res.ready) begin
                if (dac_cmd_q.size() == 0) begin
                    err_count++;
                    $display("%0t ns: unexpected result, expected none, actual code %02x%02x",
                             $time, i_res.code_high, i_res.code_low);
                end else begin
                    want = dac_cmd_q.pop_front();
                    check_field("converter_select", want.conv, i_res.converter_select);
                    check_field("register_address", want.addr, i_res.register_address);
                    check_field("code_high", want.code_hi, i_res.code_high);
                    check_field("code_low", want.code_lo, i_res.code_low);
                    check_field("clamped_mv", want.mv, i_res.clamped_mv);
                    check_field("code_saturated", want.sat, i_res.code_saturated);
                end
            end
            if (i_cmd.valid && i_cmd.ready) begin
                if (i_cmd.mode == MODE_CAL) begin
                    ch   = int'(i_cmd.channel);
                    slot = i_cmd.cal_slot;
                    if (ch < NUM_CHANNELS) begin
                        if (slot <= SLOT_RATIO_HI)
                            ratio_tbl[ch * SEG_N + int'(slot)] = i_cmd.cal_value;
                        else if (slot <= SLOT_OFFS_HI)
                            offset_tbl[ch * SEG_N + int'(slot - SLOT_OFFS_LO)] = i_cmd.cal_value;
                        else if (slot == SLOT_ZERO_STEP)
                            zero_step_tbl[ch] = i_cmd.cal_value[STEP_W-1:0];
                        else if (slot == SLOT_NEG_STEP)
                            neg_step_tbl[ch] = i_cmd.cal_value[STEP_W-1:0];
                    end
                end else begin
                    dac_cmd_q.push_back(calibrate_code(i_cmd.channel, i_cmd.voltage_mv));
                end
            end
        end
        pending = dac_cmd_q.size();
    end

endmodule

FILE: test/tb.sv
`timescale 1ns / 1ps

module tb;
    import dpcc_pkg::*;

    localparam int CMD_ITEMS   = 1750;
    localparam int CYCLE_LIMIT = 150000;
    localparam int DRAIN_WAIT  = 12;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    // Percent chance of a gap on the command side / a stall on the result side
    int send_gap_pct    = 36;
    int drain_stall_pct = 36;
    int err_count;
    int pending;
    int cycle_count = 0;

    dpcc_cmd_if cmd_bus ();
    dpcc_res_if res_bus ();

    dac_piecewise_calibrated_code_core i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_bus),
        .o_res   (res_bus)
    );

    dpcc_checker i_chk (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd_bus),
        .i_res       (res_bus),
        .o_err_count (err_count),
        .o_pending   (pending)
    );

    always #6 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Result side: random stalls, changed at the falling edge
    always @(negedge i_clk) begin
        res_bus.ready <= ($urandom_range(0, 99) >= drain_stall_pct);
    end

    // Drive one item, with random gaps ahead of it; returns at the falling
    // edge after the transfer.
    task automatic send_item(input logic mode, input logic [3:0] ch,
                             input logic signed [15:0] mv, input logic [3:0] slot,
                             input logic signed [23:0] value);
        while ($urandom_range(0, 99) < send_gap_pct) begin
            cmd_bus.valid <= 1'b0;
            @(negedge i_clk);
        end
        cmd_bus.valid      <= 1'b1;
        cmd_bus.mode       <= mode;
        cmd_bus.channel    <= ch;
        cmd_bus.voltage_mv <= mv;
        cmd_bus.cal_slot   <= slot;
        cmd_bus.cal_value  <= value;
        do @(posedge i_clk); while (!cmd_bus.ready);
        @(negedge i_clk);
    endtask

    initial begin : stimulus
        int                 tmp;
        int                 base;
        logic               mode;
        logic [3:0]         ch;
        logic [3:0]         slot;
        logic signed [15:0] mv;
        logic signed [23:0] value;

        cmd_bus.valid      = 1'b0;
        cmd_bus.mode       = MODE_CONVERT;
        cmd_bus.channel    = '0;
        cmd_bus.voltage_mv = '0;
        cmd_bus.cal_slot   = '0;
        cmd_bus.cal_value  = '0;
        res_bus.ready      = 1'b0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: empty tables, clamping, knees, saturation, steps, unmapped
        send_item(MODE_CONVERT, 4'd0, 16'sd0, SLOT_RATIO_LO, 24'sd0);
        send_item(MODE_CONVERT, 4'd0, 16'sd32767, SLOT_NEG_STEP, -24'sd1);
        send_item(MODE_CONVERT, 4'd1, -16'sd32768, 4'd15, 24'sd8388607);
        send_item(MODE_CAL, 4'd3, 16'sd0, SLOT_RATIO_LO, 24'sd8388607);
        send_item(MODE_CONVERT, 4'd3, V_KNEE, SLOT_RATIO_LO, 24'sd0);
        send_item(MODE_CAL, 4'd3, 16'sd0, SLOT_RATIO_LO + 4'd2, -24'sd8388608);
        send_item(MODE_CONVERT, 4'd3, V_NKNEE, SLOT_RATIO_LO, 24'sd0);
        send_item(MODE_CAL, 4'd3, 16'sd0, SLOT_RATIO_HI, 24'sd8388607);
        send_item(MODE_CONVERT, 4'd3, V_MIN, SLOT_RATIO_LO, 24'sd0);
        send_item(MODE_CAL, 4'd5, 16'sd0, SLOT_RATIO_LO + 4'd1, 24'sd1048576);
        send_item(MODE_CAL, 4'd5, 16'sd0, SLOT_OFFS_LO + 4'd1, -24'sd8388608);
        send_item(MODE_CONVERT, 4'd5, 16'sd10001, SLOT_RATIO_LO, 24'sd0);
        // steps written out of range keep their low 16 bits
        send_item(MODE_CAL, 4'd5, 16'sd0, SLOT_ZERO_STEP, -24'sd1);
        send_item(MODE_CONVERT, 4'd5, V_KNEE, SLOT_RATIO_LO, 24'sd0);
        send_item(MODE_CAL, 4'd5, 16'sd0, SLOT_NEG_STEP, 24'sd8388607);
        send_item(MODE_CONVERT, 4'd5, -16'sd1, SLOT_RATIO_LO, 24'sd0);
        // unused slots are dropped
        send_item(MODE_CAL, 4'd5, 16'sd0, 4'd10, 24'sd123);
        send_item(MODE_CAL, 4'd5, 16'sd0, 4'd15, -24'sd1);
        send_item(MODE_CONVERT, 4'd5, 16'sd0, SLOT_RATIO_LO, 24'sd0);
        send_item(MODE_CAL, 4'd12, 16'sd0, SLOT_OFFS_LO, 24'sd8388607);
        send_item(MODE_CONVERT, 4'd12, 16'sd0, SLOT_RATIO_LO, 24'sd0);
        // unmapped channels still report a code
        send_item(MODE_CAL, 4'd14, 16'sd0, SLOT_RATIO_LO, 24'sd1048576);
        send_item(MODE_CONVERT, 4'd14, -16'sd10001, SLOT_RATIO_LO, 24'sd0);
        send_item(MODE_CONVERT, 4'd14, 16'sd1234, SLOT_RATIO_LO, 24'sd0);
        // negative fraction truncates toward zero
        send_item(MODE_CAL, 4'd15, 16'sd0, SLOT_OFFS_LO + 4'd2, -24'sd257);
        send_item(MODE_CONVERT, 4'd15, V_NKNEE, SLOT_RATIO_LO, 24'sd0);

        // Random: mostly conversions over realistic calibration, some noise
        for (int n = 0; n < CMD_ITEMS; n++) begin
            if (n == 700) begin
                send_gap_pct    = 0;
                drain_stall_pct = 0;
            end else if (n == 1000) begin
                send_gap_pct    = 36;
                drain_stall_pct = 36;
            end
            mode  = ($urandom_range(0, 99) < 25) ? MODE_CAL : MODE_CONVERT;
            ch    = 4'($urandom_range(0, 15));
            slot  = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(10, 15))
                                                : 4'($urandom_range(0, 9));
            value = 24'($urandom);
            mv    = 16'($urandom);
            if (mode == MODE_CAL) begin
                if ($urandom_range(0, 9) < 7) begin
                    if (slot <= SLOT_OFFS_HI)
                        tmp = int'($urandom_range(0, 2097152)) - 1048576;
                    else
                        tmp = int'($urandom_range(0, 2000));
                    value = tmp[23:0];
                end
            end else begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3, 4: begin
                        tmp = int'($urandom_range(0, 50000)) - 25000;
                        mv  = tmp[15:0];
                    end
                    5, 6: begin
                        case ($urandom_range(0, 4))
                            0:       base = 10000;
                            1:       base = -10000;
                            2:       base = 25000;
                            3:       base = -25000;
                            default: base = 0;
                        endcase
                        tmp = base + int'($urandom_range(0, 6)) - 3;
                        mv  = tmp[15:0];
                    end
                    7, 8: ;
                    default: mv = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
                endcase
            end
            send_item(mode, ch, mv, slot, value);
        end
        cmd_bus.valid <= 1'b0;

        while (pending != 0) @(negedge i_clk);
        repeat (DRAIN_WAIT) @(negedge i_clk);
        if (err_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
